// ===== rtl/lkv_pkg.sv =====
// lkv_pkg: shared constants and types for the lru key/value cache
// no dependencies; used by lkv_store, lru_key_value_cache_unit and the bench
package lkv_pkg;

  // default geometry
  localparam int CAPACITY_DEFAULT  = 8;
  localparam int KEY_WIDTH_DEFAULT = 32;

  // fixed port widths
  localparam int KEY_PORT_W = 32;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 4;

  // capacity register reset value
  localparam logic [CFG_W-1:0] CAPACITY_RESET = 4'd8;

  // operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // request into the entry store
  typedef struct packed {
    logic              fire;
    logic              is_put;
    logic [DATA_W-1:0] value;
  } lkv_req_t;

  // response from the entry store, valid in the cycle of the request
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [DATA_W-1:0] read_value;
  } lkv_resp_t;

endpackage

// ===== rtl/lkv_store.sv =====
// lkv_store: fully associative entry store with parallel tag compare and age ranks
// depends on lkv_pkg
module lkv_store #(
  parameter int CAPACITY = lkv_pkg::CAPACITY_DEFAULT,
  parameter int KEY_W    = lkv_pkg::KEY_WIDTH_DEFAULT,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  lkv_pkg::lkv_req_t req,
  input  logic [KEY_W-1:0]  key,
  input  logic [CNT_W-1:0]  cap_eff,
  output lkv_pkg::lkv_resp_t resp
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int DW     = lkv_pkg::DATA_W;

  logic [KEY_W-1:0]    entry_keys   [CAPACITY];
  logic [DW-1:0]       entry_values [CAPACITY];
  logic [CAPACITY-1:0] entry_valid, entry_valid_next;
  logic [RANK_W-1:0]   entry_rank      [CAPACITY];
  logic [RANK_W-1:0]   entry_rank_next [CAPACITY];
  logic [CNT_W-1:0]    count, count_next;

  logic [CAPACITY-1:0] match, found_oh, free_oh, oldest_oh, slot_oh, top_vec;
  logic [RANK_W-1:0]   found_rank;
  logic [DW-1:0]       found_value;
  logic [RANK_W-1:0]   oldest_rank;
  logic                hit, full, do_insert, do_evict;

  // oldest valid entry carries rank count-1, ranks form a permutation
  assign oldest_rank = RANK_W'(count - CNT_W'(1));

  // tag compare and per-entry flags
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]     = entry_valid[i] && (entry_keys[i] == key);
      oldest_oh[i] = entry_valid[i] && (entry_rank[i] == oldest_rank);
      top_vec[i]   = entry_valid[i] && (entry_rank[i] == '0);
    end
  end

  // lowest matching entry and lowest free entry
  assign found_oh = match & (~match + CAPACITY'(1));
  assign free_oh  = ~entry_valid & (entry_valid + CAPACITY'(1));

  // read the matched entry
  always_comb begin
    found_rank  = '0;
    found_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (found_oh[i]) begin
        found_rank  = found_rank | entry_rank[i];
        found_value = found_value | entry_values[i];
      end
    end
  end

  // replacement decision
  assign hit       = |match;
  assign full      = (count >= cap_eff);
  assign do_insert = req.is_put && !hit;
  assign do_evict  = do_insert && full;
  assign slot_oh   = do_evict ? oldest_oh : free_oh;

  // next valid bits, ranks and fill count
  always_comb begin
    entry_valid_next = entry_valid;
    count_next       = count;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_rank_next[i] = entry_rank[i];
    end
    if (req.fire) begin
      if (hit) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (found_oh[i]) begin
            entry_rank_next[i] = '0;
          end else if (entry_valid[i] && (entry_rank[i] < found_rank)) begin
            entry_rank_next[i] = entry_rank[i] + RANK_W'(1);
          end
        end
      end else if (req.is_put) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_oh[i]) begin
            entry_valid_next[i] = 1'b1;
            entry_rank_next[i]  = '0;
          end else if (entry_valid[i]) begin
            entry_rank_next[i] = entry_rank[i] + RANK_W'(1);
          end
        end
        if (!do_evict) begin
          count_next = count + CNT_W'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      count       <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        entry_rank[i] <= '0;
      end
    end else begin
      entry_valid <= entry_valid_next;
      count       <= count_next;
      for (int i = 0; i < CAPACITY; i++) begin
        entry_rank[i] <= entry_rank_next[i];
      end
    end
  end

  // key and value storage, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (req.fire && ((hit && req.is_put && found_oh[i]) || (do_insert && slot_oh[i]))) begin
        entry_values[i] <= req.value;
      end
      if (req.fire && do_insert && slot_oh[i]) begin
        entry_keys[i] <= key;
      end
    end
  end

  // response for the word in flight
  assign resp.hit        = hit;
  assign resp.evicted    = do_evict;
  assign resp.read_value = (hit && !req.is_put) ? found_value : '0;

  // fill count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(entry_valid))
    else $error("fill count differs from number of valid entries");

  // at most one most recent entry
  a_one_recent: assert property (@(posedge clk) disable iff (rst)
    $onehot0(top_vec))
    else $error("more than one entry holds rank zero");

  // a non-empty store has exactly one oldest entry
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> $onehot(oldest_oh))
    else $error("oldest entry not unique");

  // eviction only on a put of a new key
  a_evict_cause: assert property (@(posedge clk) disable iff (rst)
    (req.fire && do_evict) |-> (req.is_put && !hit))
    else $error("eviction without a missing put");

  // a put always leaves the store non-empty
  a_put_fills: assert property (@(posedge clk) disable iff (rst)
    (req.fire && req.is_put) |=> (entry_valid != '0))
    else $error("store empty after a put");

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// lru_key_value_cache_unit: fully associative key/value cache, lru replacement
// depends on lkv_pkg and lkv_store
// a word waits in the input register until the result register is free or
// draining; throughput: one word per cycle unless out_ready stalls, set by the
//   combinational tag compare and rank update between the two registers
// reset: all entries invalid, no recent key, capacity register back to 8
module lru_key_value_cache_unit #(
  parameter int CAPACITY  = lkv_pkg::CAPACITY_DEFAULT,
  parameter int KEY_WIDTH = lkv_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write_enable,
  input  logic [lkv_pkg::CFG_W-1:0] cfg_write_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [31:0]              key_tag,
  input  logic signed [31:0]       put_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [31:0]       read_value,
  output logic                     evicted,
  output logic [31:0]              recent_key,
  output logic                     recent_valid
);

  localparam int PORT_W = lkv_pkg::KEY_PORT_W;
  localparam int KEY_W  = (KEY_WIDTH < PORT_W) ? KEY_WIDTH : PORT_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CFG_W  = lkv_pkg::CFG_W;
  localparam int DW     = lkv_pkg::DATA_W;

  logic [CFG_W-1:0]   cap_reg;
  logic [CNT_W-1:0]   cap_eff;

  logic               in_full;
  logic               op_q;
  logic [KEY_W-1:0]   key_q;
  logic [DW-1:0]      value_q;
  logic               advance;

  logic [KEY_W-1:0]   recent_key_state, recent_key_state_next;
  logic               recent_valid_state, recent_valid_state_next;

  lkv_pkg::lkv_req_t  req;
  lkv_pkg::lkv_resp_t resp;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= lkv_pkg::CAPACITY_RESET;
    end else if (cfg_write_enable) begin
      cap_reg <= cfg_write_data;
    end
  end

  // clamp capacity to one..CAPACITY
  always_comb begin
    if (cap_reg == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_reg) > 32'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = CNT_W'(cap_reg);
    end
  end

  // handshake: stage advances when the result register is free or draining
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= operation;
      key_q   <= key_tag[KEY_W-1:0];
      value_q <= put_value;
    end
  end

  // entry store
  assign req.fire   = advance;
  assign req.is_put = (op_q == lkv_pkg::OP_PUT);
  assign req.value  = value_q;

  lkv_store #(
    .CAPACITY (CAPACITY),
    .KEY_W    (KEY_W),
    .CNT_W    (CNT_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .key     (key_q),
    .cap_eff (cap_eff),
    .resp    (resp)
  );

  // most recent key: the key just touched by a hit or a put
  always_comb begin
    recent_key_state_next   = recent_key_state;
    recent_valid_state_next = recent_valid_state;
    if (resp.hit || req.is_put) begin
      recent_key_state_next   = key_q;
      recent_valid_state_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_key_state   <= '0;
      recent_valid_state <= 1'b0;
    end else if (advance) begin
      recent_key_state   <= recent_key_state_next;
      recent_valid_state <= recent_valid_state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit          <= resp.hit;
      read_value   <= resp.read_value;
      evicted      <= resp.evicted;
      recent_key   <= PORT_W'(recent_key_state_next);
      recent_valid <= recent_valid_state_next;
    end
  end

  // once an entry exists the cache never empties
  a_recent_sticky: assert property (@(posedge clk) disable iff (rst)
    recent_valid_state |=> recent_valid_state)
    else $error("recent entry lost");

  // a put word always reports a recent entry
  a_put_recent: assert property (@(posedge clk) disable iff (rst)
    (advance && req.is_put) |=> (out_valid && recent_valid))
    else $error("put word without recent entry");

  // a put never returns data
  a_put_no_data: assert property (@(posedge clk) disable iff (rst)
    (advance && req.is_put) |=> (read_value == '0))
    else $error("put word returned data");

endmodule

// ===== bench/lru_key_value_cache_unit_tb.sv =====
`timescale 1ns / 1ps
// lru_key_value_cache_unit_tb: self-checking bench for the lru key/value cache
// depends on lkv_pkg and lru_key_value_cache_unit; a table of directed words,
// then random words in phases, every result checked against its table entry or an lru predictor
module lru_key_value_cache_unit_tb;

  localparam int SLOTS        = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 125;
  localparam int POOL_SIZE    = 10;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] recent_key;
    logic        recent_valid;
  } lookup_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic                     op;
    logic [31:0]              key;
    logic [31:0]              value;
    logic [lkv_pkg::CFG_W-1:0] capacity;
    logic                     typed;
    lookup_result_t           result;
  } step_row_t;

  localparam lookup_result_t FROM_PREDICTOR = '0;
  localparam int DIRECTED_ROWS = 26;

  // directed words: extremes, hit and miss, update, eviction, capacity corners
  localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd0, 1'b1,
      '{1'b0, 32'h0, 1'b0, 32'h0, 1'b0}},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'hFFFFFFFF, 32'h80000000, 4'd0, 1'b1,
      '{1'b0, 32'h0, 1'b0, 32'hFFFFFFFF, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'hFFFFFFFF, 32'h0, 4'd0, 1'b1,
      '{1'b1, 32'h80000000, 1'b0, 32'hFFFFFFFF, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h0, 32'h7FFFFFFF, 4'd0, 1'b1,
      '{1'b0, 32'h0, 1'b0, 32'h0, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd0, 1'b1,
      '{1'b1, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'hFFFFFFFF, 32'h0, 4'd0, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'hFFFFFFFF, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0, 32'hFFFFFFFF, 4'd0, 1'b1,
      '{1'b1, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h1, 32'h1, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h2, 32'hFFFFFFFF, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h3, 32'h3, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h4, 32'h80000001, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h5, 32'h5, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h6, 32'h6, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h5A5A5A5A, 32'h55555555, 4'd0, 1'b1,
      '{1'b0, 32'h0, 1'b1, 32'h5A5A5A5A, 1'b1}},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'hFFFFFFFF, 32'h0, 4'd0, 1'b1,
      '{1'b0, 32'h0, 1'b0, 32'h5A5A5A5A, 1'b1}},
    '{ROW_CFG, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd2, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h12345678, 32'hAAAAAAAA, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h87654321, 32'h11111111, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_CFG, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'hA5A5A5A5, 32'h22222222, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_GET, 32'h87654321, 32'h0, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_CFG, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd15, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h00000100, 32'h33333333, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_ITEM, lkv_pkg::OP_PUT, 32'h7, 32'h44444444, 4'd0, 1'b0, FROM_PREDICTOR},
    '{ROW_CFG, lkv_pkg::OP_GET, 32'h0, 32'h0, 4'd8, 1'b0, FROM_PREDICTOR}
  };

  localparam logic [lkv_pkg::CFG_W-1:0] PHASE_CAPACITY [PHASES] =
    '{4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd9, 4'd2, 4'd5};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write_enable = 1'b0;
  logic [lkv_pkg::CFG_W-1:0] cfg_write_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      operation = lkv_pkg::OP_GET;
  logic [31:0]               key_tag = '0;
  logic signed [31:0]        put_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      hit;
  logic signed [31:0]        read_value;
  logic                      evicted;
  logic [31:0]               recent_key;
  logic                      recent_valid;

  // predictor copy of the cache
  logic [31:0]               slot_key   [SLOTS];
  logic [31:0]               slot_value [SLOTS];
  logic                      slot_live  [SLOTS];
  logic [2:0]                slot_age   [SLOTS];
  logic [lkv_pkg::CFG_W-1:0] capacity_reg;

  lookup_result_t pending_lookups [$];
  logic [31:0]    key_pool [POOL_SIZE];
  int             gap_pct = 0;
  int             stall_pct = 0;
  int             mismatches = 0;
  int             quiet_cycles = 0;

  lru_key_value_cache_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .key_tag          (key_tag),
    .put_value        (put_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .hit              (hit),
    .read_value       (read_value),
    .evicted          (evicted),
    .recent_key       (recent_key),
    .recent_valid     (recent_valid)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // one lookup or store through the lru predictor
  function automatic lookup_result_t lru_lookup(logic op, logic [31:0] key,
                                                logic [31:0] value);
    lookup_result_t r;
    int found;
    int count;
    int oldest;
    int free_slot;
    int limit;
    logic [2:0] age;
    r = '0;
    found = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (op == lkv_pkg::OP_PUT) slot_value[found] = value;
      else r.read_value = slot_value[found];
      age = slot_age[found];
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && i != found && slot_age[i] < age) slot_age[i]++;
      slot_age[found] = 3'd0;
    end else if (op == lkv_pkg::OP_PUT) begin
      count = 0;
      oldest = -1;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_live[i]) begin
          count++;
          if (oldest < 0 || slot_age[i] > slot_age[oldest]) oldest = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      limit = (capacity_reg == 0) ? 1 :
              (int'(capacity_reg) > SLOTS) ? SLOTS : int'(capacity_reg);
      if ((count >= limit || free_slot < 0) && oldest >= 0) begin
        slot_live[oldest] = 1'b0;
        free_slot = oldest;
        r.evicted = 1'b1;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_live[free_slot]  = 1'b1;
        slot_key[free_slot]   = key;
        slot_value[free_slot] = value;
        slot_age[free_slot]   = 3'd0;
      end
    end
    for (int i = 0; i < SLOTS; i++)
      if (!r.recent_valid && slot_live[i] && slot_age[i] == 3'd0) begin
        r.recent_key   = slot_key[i];
        r.recent_valid = 1'b1;
      end
    return r;
  endfunction

  // offer one word, wait for acceptance, record what should come back
  task automatic send_word(logic op, logic [31:0] key, logic [31:0] value,
                           logic typed, lookup_result_t typed_result);
    lookup_result_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key_tag   <= key;
    put_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = lru_lookup(op, key, value);
    pending_lookups.push_back(typed ? typed_result : predicted);
  endtask

  // stop offering words until every result is back
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CFG_W-1:0] value);
    cfg_write_data   <= value;
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    capacity_reg = value;
  endtask

  // stimulus
  initial begin
    int pick;
    logic [31:0] key;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i]  = 3'd0;
    end
    capacity_reg = lkv_pkg::CAPACITY_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        settle_idle();
        write_capacity(DIRECTED[r].capacity);
      end else begin
        send_word(DIRECTED[r].op, DIRECTED[r].key, DIRECTED[r].value,
                  DIRECTED[r].typed, DIRECTED[r].result);
      end
    end

    // random phases, each with its own capacity and one of four idling patterns
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      write_capacity(PHASE_CAPACITY[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // in phase 2, hold off once mid-phase until the cache has drained
        if (p == 2 && n == PHASE_WORDS / 2) settle_idle();
        pick = $urandom_range(99);
        key = (pick < 80) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
        send_word(1'($urandom_range(1)), key, $urandom, 1'b0, FROM_PREDICTOR);
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("lru_key_value_cache_unit_tb OK");
    end else begin
      $display("lru_key_value_cache_unit_tb NOT OK");
    end
    $finish;
  end

  // result side: random stalls and checking of each accepted word
  always @(posedge clk) begin
    lookup_result_t want;
    if (out_valid && out_ready && !rst) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t unexpected result word: hit %0b read_value %h recent_key %h",
                 $time, hit, read_value, recent_key);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        if (hit !== want.hit) begin
          $display("%0t hit: expected %0b actual %0b", $time, want.hit, hit);
          mismatches++;
        end
        if (read_value !== want.read_value) begin
          $display("%0t read_value: expected %h actual %h", $time, want.read_value,
                   read_value);
          mismatches++;
        end
        if (evicted !== want.evicted) begin
          $display("%0t evicted: expected %0b actual %0b", $time, want.evicted, evicted);
          mismatches++;
        end
        if (recent_key !== want.recent_key) begin
          $display("%0t recent_key: expected %h actual %h", $time, want.recent_key,
                   recent_key);
          mismatches++;
        end
        if (recent_valid !== want.recent_valid) begin
          $display("%0t recent_valid: expected %0b actual %0b", $time,
                   want.recent_valid, recent_valid);
          mismatches++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("lru_key_value_cache_unit_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
